@@ rtl/core/lsd_pkg.sv @@
// shared types and constants of the lorentzian spectral density block
package lsd_pkg;

	// command codes of a request
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_DENSITY = 2'd1;
	localparam logic [1:0] CMD_DERIV   = 2'd2;

	// multiplier operand width, wide enough for the denominator sum
	localparam int MUL_W = 66;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_LATCH,
		ST_MUL_G2,
		ST_MUL_S,
		ST_MUL_N,
		ST_MUL_ND,
		ST_MUL_SS,
		ST_DIV,
		ST_ACC,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_LATCH,
		OP_MUL,
		OP_SETUP_S,
		OP_SETUP_N,
		OP_SETUP_ND,
		OP_SETUP_SS,
		OP_DIV_START,
		OP_DIV,
		OP_ACC,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic eval;
		logic deriv;
		logic count_zero;
		logic mul_zero;
		logic div_last;
		logic last_term;
	} dp_stat_t;

endpackage

@@ rtl/core/lsd_req_if.sv @@
// request channel: valid, ready and the request payload
interface lsd_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [3:0]         peak_index;
	logic signed [31:0] center;
	logic signed [31:0] half_width;
	logic signed [31:0] peak_height;
	logic signed [31:0] omega;

	modport source (
		output valid, cmd, peak_index, center, half_width, peak_height, omega,
		input  ready
	);
	modport sink (
		input  valid, cmd, peak_index, center, half_width, peak_height, omega,
		output ready
	);
endinterface

@@ rtl/core/lsd_rsp_if.sv @@
// response channel: valid, ready and the result payload
interface lsd_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               saturated;
	logic               status;

	modport source (
		output valid, value, saturated, status,
		input  ready
	);
	modport sink (
		input  valid, value, saturated, status,
		output ready
	);
endinterface

@@ rtl/core/lsd_ram.sv @@
// generic single write port ram with registered read
module lsd_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/lsd_ctrl.sv @@
// controller state machine sequencing loads and evaluations
module lsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lsd_pkg::dp_cmd_t  dp_cmd,
	input  lsd_pkg::dp_stat_t dp_stat
);
	import lsd_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_vld_q;
	logic   can_finish;

	assign can_finish = !rsp_vld_q || rsp_ready;
	assign rsp_valid  = rsp_vld_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (dp_stat.eval && !dp_stat.count_zero) state_nxt = ST_READ;
				else state_nxt = ST_FINISH;
			end
			ST_READ:  state_nxt = ST_LATCH;
			ST_LATCH: state_nxt = ST_MUL_G2;
			ST_MUL_G2: begin
				if (dp_stat.mul_zero) state_nxt = ST_MUL_S;
			end
			ST_MUL_S: begin
				if (dp_stat.mul_zero) state_nxt = ST_MUL_N;
			end
			ST_MUL_N: begin
				if (dp_stat.mul_zero) state_nxt = dp_stat.deriv ? ST_MUL_ND : ST_DIV;
			end
			ST_MUL_ND: begin
				if (dp_stat.mul_zero) state_nxt = ST_MUL_SS;
			end
			ST_MUL_SS: begin
				if (dp_stat.mul_zero) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (dp_stat.div_last) state_nxt = ST_ACC;
			end
			ST_ACC: begin
				state_nxt = dp_stat.last_term ? ST_FINISH : ST_READ;
			end
			ST_FINISH: begin
				if (can_finish) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands and request ready
	always_comb begin
		dp_cmd.op = OP_NOP;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) dp_cmd.op = OP_ACCEPT;
			end
			ST_DECIDE, ST_READ: dp_cmd.op = OP_NOP;
			ST_LATCH: dp_cmd.op = OP_LATCH;
			ST_MUL_G2: dp_cmd.op = dp_stat.mul_zero ? OP_SETUP_S : OP_MUL;
			ST_MUL_S:  dp_cmd.op = dp_stat.mul_zero ? OP_SETUP_N : OP_MUL;
			ST_MUL_N: begin
				if (!dp_stat.mul_zero) dp_cmd.op = OP_MUL;
				else dp_cmd.op = dp_stat.deriv ? OP_SETUP_ND : OP_DIV_START;
			end
			ST_MUL_ND: dp_cmd.op = dp_stat.mul_zero ? OP_SETUP_SS : OP_MUL;
			ST_MUL_SS: dp_cmd.op = dp_stat.mul_zero ? OP_DIV_START : OP_MUL;
			ST_DIV:    dp_cmd.op = OP_DIV;
			ST_ACC:    dp_cmd.op = OP_ACC;
			ST_FINISH: begin
				if (can_finish) dp_cmd.op = OP_FINISH;
			end
			default: dp_cmd.op = OP_NOP;
		endcase
	end

	// state and response valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_FINISH && can_finish) rsp_vld_q <= 1'b1;
			else if (rsp_ready) rsp_vld_q <= 1'b0;
		end
	end
endmodule

@@ rtl/core/lsd_datapath.sv @@
// datapath: peak table, shift-add multiplier, restoring divider, accumulator
module lsd_datapath #(
	parameter int MAX_PEAKS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  logic [1:0]         req_cmd,
	input  logic [3:0]         req_peak_index,
	input  logic signed [31:0] req_center,
	input  logic signed [31:0] req_half_width,
	input  logic signed [31:0] req_peak_height,
	input  logic signed [31:0] req_omega,
	output logic signed [31:0] rsp_value,
	output logic               rsp_saturated,
	output logic               rsp_status,
	input  lsd_pkg::dp_cmd_t   dp_cmd,
	output lsd_pkg::dp_stat_t  dp_stat
);
	import lsd_pkg::*;

	localparam int AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int CW = $clog2(MAX_PEAKS + 1);
	localparam int QW = 32 + FRAC_BITS;
	localparam int WW = 130 + FRAC_BITS;
	localparam int DCW = $clog2(QW);

	logic [4:0]          peak_count_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       term_q;
	logic                eval_q;
	logic                deriv_q;
	logic                status_q;
	logic signed [31:0]  omega_q;
	logic [31:0]         ha_q;
	logic                hneg_q;
	logic [32:0]         da_q;
	logic                dneg_q;
	logic [63:0]         g2_q;
	logic [MUL_W-1:0]    s_q;
	logic [WW-1:0]       mc_q;
	logic [MUL_W-1:0]    mp_q;
	logic [WW-1:0]       prod_q;
	logic [WW-1:0]       num_q;
	logic [WW-1:0]       den_q;
	logic [WW:0]         rem_q;
	logic [QW-1:0]       nl_q;
	logic [QW-1:0]       quot_q;
	logic [DCW-1:0]      dcnt_q;
	logic signed [63:0]  sum_q;
	logic signed [31:0]  value_q;
	logic                sat_q;
	logic                stat_out_q;

	logic [8:0]          idx_w;
	logic [8:0]          pc_w;
	logic                ram_we;
	logic [95:0]         ram_rdata;
	logic [AW-1:0]       ram_raddr;
	logic signed [31:0]  rd_h;
	logic signed [31:0]  rd_g;
	logic signed [31:0]  rd_c;
	logic signed [32:0]  rd_d;
	logic [31:0]         rd_ga;
	logic [WW-1:0]       div_n;
	logic [WW-1:0]       div_d;
	logic [WW:0]         div_t;
	logic [WW:0]         div_diff;
	logic                div_ge;
	logic                term_neg;
	logic signed [63:0]  mag64;
	logic [CW-1:0]       term_inc;

	// table write on an accepted load with positive width and index in range
	assign idx_w  = 9'(req_peak_index);
	assign pc_w   = 9'(peak_count_q);
	assign ram_we = (dp_cmd.op == OP_ACCEPT) && (req_cmd == CMD_LOAD) &&
		(req_half_width > 32'sd0) && (idx_w < 9'(MAX_PEAKS));
	assign ram_raddr = term_q[AW-1:0];

	lsd_ram #(
		.WIDTH (96),
		.DEPTH (MAX_PEAKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_w[AW-1:0]),
		.wdata ({req_peak_height, req_half_width, req_center}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// unpack the entry read for the current term
	assign rd_h  = ram_rdata[95:64];
	assign rd_g  = ram_rdata[63:32];
	assign rd_c  = ram_rdata[31:0];
	assign rd_d  = {omega_q[31], omega_q} - {rd_c[31], rd_c};
	assign rd_ga = rd_g[31] ? 32'(-rd_g) : 32'(rd_g);

	// divider operands and one restoring step
	assign div_n    = deriv_q ? num_q : prod_q;
	assign div_d    = deriv_q ? prod_q : WW'(s_q);
	assign div_t    = {rem_q[WW-1:0], nl_q[QW-1]};
	assign div_diff = div_t - {1'b0, den_q};
	assign div_ge   = (div_t >= {1'b0, den_q});

	// term sign and magnitude
	assign term_neg = deriv_q ? (hneg_q == dneg_q) : hneg_q;
	assign mag64    = signed'(64'(quot_q));
	assign term_inc = term_q + CW'(1);

	assign dp_stat.eval       = eval_q;
	assign dp_stat.deriv      = deriv_q;
	assign dp_stat.count_zero = (count_q == '0);
	assign dp_stat.mul_zero   = (mp_q == '0);
	assign dp_stat.div_last   = (dcnt_q == '0);
	assign dp_stat.last_term  = (term_inc == count_q);

	assign rsp_value     = value_q;
	assign rsp_saturated = sat_q;
	assign rsp_status    = stat_out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_count_q <= '0;
		end else if (cfg_we) begin
			peak_count_q <= cfg_wdata;
		end
	end

	// item control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_q   <= 1'b0;
			deriv_q  <= 1'b0;
			status_q <= 1'b0;
			count_q  <= '0;
			term_q   <= '0;
			dcnt_q   <= '0;
		end else begin
			unique case (dp_cmd.op)
				OP_ACCEPT: begin
					eval_q   <= (req_cmd == CMD_DENSITY) || (req_cmd == CMD_DERIV);
					deriv_q  <= (req_cmd == CMD_DERIV);
					status_q <= (req_cmd == CMD_LOAD) && (req_half_width <= 32'sd0);
					count_q  <= (pc_w > 9'(MAX_PEAKS)) ? CW'(MAX_PEAKS) : CW'(pc_w);
					term_q   <= '0;
				end
				OP_DIV_START: dcnt_q <= DCW'(QW - 1);
				OP_DIV:       dcnt_q <= dcnt_q - DCW'(1);
				OP_ACC:       term_q <= term_inc;
				default: ;
			endcase
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (dp_cmd.op)
			OP_ACCEPT: begin
				omega_q <= req_omega;
				sum_q   <= '0;
			end
			OP_LATCH: begin
				hneg_q <= rd_h[31];
				ha_q   <= rd_h[31] ? 32'(-rd_h) : 32'(rd_h);
				dneg_q <= rd_d[32];
				da_q   <= rd_d[32] ? 33'(-rd_d) : 33'(rd_d);
				mc_q   <= WW'(rd_ga);
				mp_q   <= MUL_W'(rd_ga);
				prod_q <= '0;
			end
			OP_MUL: begin
				prod_q <= prod_q + (mp_q[0] ? mc_q : '0);
				mc_q   <= mc_q << 1;
				mp_q   <= mp_q >> 1;
			end
			OP_SETUP_S: begin
				// keep g^2 in the product so d^2 adds onto it
				g2_q <= prod_q[63:0];
				mc_q <= WW'(da_q);
				mp_q <= MUL_W'(da_q);
			end
			OP_SETUP_N: begin
				s_q    <= prod_q[MUL_W-1:0];
				mc_q   <= WW'(g2_q);
				mp_q   <= MUL_W'(ha_q);
				prod_q <= '0;
			end
			OP_SETUP_ND: begin
				mc_q   <= prod_q;
				mp_q   <= MUL_W'(da_q);
				prod_q <= '0;
			end
			OP_SETUP_SS: begin
				num_q  <= prod_q << (FRAC_BITS + 1);
				mc_q   <= WW'(s_q);
				mp_q   <= s_q;
				prod_q <= '0;
			end
			OP_DIV_START: begin
				rem_q  <= (WW + 1)'(div_n >> QW);
				nl_q   <= div_n[QW-1:0];
				den_q  <= div_d;
				quot_q <= '0;
			end
			OP_DIV: begin
				rem_q  <= div_ge ? div_diff : div_t;
				quot_q <= {quot_q[QW-2:0], div_ge};
				nl_q   <= nl_q << 1;
			end
			OP_ACC: begin
				sum_q <= term_neg ? (sum_q - mag64) : (sum_q + mag64);
			end
			default: ;
		endcase
	end

	// result register with clipping to the 32-bit range
	always_ff @(posedge clk) begin
		if (dp_cmd.op == OP_FINISH) begin
			stat_out_q <= status_q;
			if (sum_q > 64'sh7FFF_FFFF) begin
				value_q <= 32'sh7FFF_FFFF;
				sat_q   <= 1'b1;
			end else if (sum_q < -64'sh8000_0000) begin
				value_q <= 32'sh8000_0000;
				sat_q   <= 1'b1;
			end else begin
				value_q <= 32'(sum_q);
				sat_q   <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/lorentzian_spectral_density.sv @@
// a load or an evaluation over zero peaks passes from DECIDE straight to FINISH
// an evaluation reads each peak and forms g^2 + d^2 and h*g^2 on the shift-add multiplier
// (plus numerator*d and s^2 for the derivative), divides to 32+FRAC_BITS bits and accumulates
// throughput: one item at a time; the next request is taken once the result is registered
// reset: arst_n clears the controller, peak_count and response valid; table is not cleared
module lorentzian_spectral_density #(
	parameter int MAX_PEAKS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	lsd_req_if.sink    req,
	lsd_rsp_if.source  rsp
);
	import lsd_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// sequencing
	lsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	// arithmetic and table
	lsd_datapath #(
		.MAX_PEAKS (MAX_PEAKS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req_cmd         (req.cmd),
		.req_peak_index  (req.peak_index),
		.req_center      (req.center),
		.req_half_width  (req.half_width),
		.req_peak_height (req.peak_height),
		.req_omega       (req.omega),
		.rsp_value       (rsp.value),
		.rsp_saturated   (rsp.saturated),
		.rsp_status      (rsp.status),
		.dp_cmd          (dp_cmd),
		.dp_stat         (dp_stat)
	);
endmodule

@@ rtl/core/lsd_checker.sv @@
// port-level checks of the lorentzian spectral density block and their bind
module lsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] rsp_value,
	input logic               rsp_saturated,
	input logic               rsp_status
);
	// a stalled response holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
		$stable(rsp_saturated) && $stable(rsp_status))
	else $error("stalled response changed");

	// a refused load carries a zero value and no clipping
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_value == 32'sd0 && !rsp_saturated)
	else $error("refused load with nonzero result");

	// clipping only lands on the range limits
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_saturated |->
		rsp_value == 32'sh7FFF_FFFF || rsp_value == 32'sh8000_0000)
	else $error("saturated value not at a limit");

	// one item at a time: ready drops after a request transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("request taken while busy");
endmodule

bind lorentzian_spectral_density lsd_checker u_lsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value     (rsp.value),
	.rsp_saturated (rsp.saturated),
	.rsp_status    (rsp.status)
);
